>>> src/mrfvle_pkg.sv
package mrfvle_pkg;

  localparam int STEPS         = 32;
  localparam int MAX_TRIANGLES = 16;

  localparam int STEP_W   = 6;
  localparam int CNT_W    = 7;
  localparam int LIN_W    = 13;
  localparam int QUAD_W   = 18;
  localparam int GAIN_W   = 24;
  localparam int ENERGY_W = 48;
  localparam int HALF_W   = 18;
  localparam int DSQ_W    = 2 * STEP_W;
  localparam int DL_W     = STEP_W + LIN_W;
  localparam int MT_W     = GAIN_W + DSQ_W;
  localparam int NT_W     = GAIN_W + HALF_W + 1;

  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam int JQ_DEPTH = 2;
  localparam int JQ_AW    = $clog2(JQ_DEPTH);
  localparam int RQ_DEPTH = 8;
  localparam int RQ_AW    = $clog2(RQ_DEPTH);

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(STEPS - 1);
  localparam logic [CNT_W-1:0]  TRI_LIMIT = CNT_W'(MAX_TRIANGLES);

  // register index, taken from paddr[2]
  localparam logic REG_MEAN_GAIN      = 1'b0;
  localparam logic REG_NEIGHBOUR_GAIN = 1'b1;

  typedef struct packed {
    logic [STEP_W-1:0] vertex_mean;
    logic [STEP_W-1:0] neighbour_delta_a;
    logic [STEP_W-1:0] neighbour_delta_b;
    logic              has_triangle;
    logic              last_triangle;
  } in_item_t;

  typedef struct packed {
    logic [STEP_W-1:0]   step_index;
    logic [ENERGY_W-1:0] energy;
    logic                last_step;
  } out_item_t;

  typedef struct packed {
    logic [GAIN_W-1:0] mean_gain;
    logic [GAIN_W-1:0] neighbour_gain;
  } gains_t;

  // one vertex worth of accumulated sums
  typedef struct packed {
    logic [CNT_W-1:0]  tri_count;
    logic [LIN_W-1:0]  lin_sum;
    logic [QUAD_W-1:0] quad_sum;
    logic [STEP_W-1:0] mean;
  } job_t;

endpackage

>>> src/mrf_vertex_label_energy_unit.sv
// MRF vertex label energy unit. Items for one vertex arrive on the push side,
// one per cycle; each may carry one adjacent triangle (the two other corners'
// current steps) and the item flagged last_triangle closes the vertex. The
// front end folds triangles into running sums (count, b+c, b^2+c^2-bc),
// capped at MAX_TRIANGLES, and on the last item hands the sums plus that
// item's vertex_mean to a two-entry job queue, so the next vertex can stream
// in while the previous one is still being evaluated. The back end walks the
// candidate steps d = 0..STEPS-1 through a three-stage multiply pipeline,
// one energy per cycle while the result queue has room, into an eight-entry
// result queue; last_step marks d = STEPS-1. energy = mean_gain*(d-m)^2 +
// neighbour_gain*2*(T*d^2 + Q - d*L), clamped at 2^48-1. Throughput: one
// input item per cycle while the job queue has room; each vertex occupies
// the back end for a load state and then one step per cycle, so sustained
// rate is set by the single step pipeline and the consumer's pop rate. Gains
// sit at 0x00 (mean_gain) and 0x04 (neighbour_gain); write them only while
// the unit is idle.
module mrf_vertex_label_energy_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mrfvle_pkg::ADDR_W-1:0] paddr,
  input  logic [mrfvle_pkg::DATA_W-1:0] pwdata,
  output logic [mrfvle_pkg::DATA_W-1:0] prdata,
  output logic                          pready,
  input  logic                          push,
  input  mrfvle_pkg::in_item_t          in_item,
  output logic                          full,
  output logic                          empty,
  input  logic                          pop,
  output mrfvle_pkg::out_item_t         out_item
);
  import mrfvle_pkg::*;

  gains_t gains;
  job_t   fe_job, be_job;
  logic   jq_wr, jq_full, jq_rd, jq_empty;

  assign pready = 1'b1;

  // gain registers
  mrfvle_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .gains   (gains)
  );

  // triangle accumulation; stalls only when the job queue is full
  mrfvle_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .in_item  (in_item),
    .full     (full),
    .job_full (jq_full),
    .job_push (jq_wr),
    .job      (fe_job)
  );

  // decouples accumulation from per-step evaluation
  mrfvle_job_queue u_jq (
    .clk    (clk),
    .rst    (rst),
    .wr     (jq_wr),
    .wr_job (fe_job),
    .full   (jq_full),
    .rd     (jq_rd),
    .empty  (jq_empty),
    .rd_job (be_job)
  );

  // step sequencer, energy pipeline and result queue
  mrfvle_back u_back (
    .clk       (clk),
    .rst       (rst),
    .gains     (gains),
    .job_empty (jq_empty),
    .job_head  (be_job),
    .job_pop   (jq_rd),
    .pop       (pop),
    .empty     (empty),
    .out_item  (out_item)
  );

endmodule

>>> src/mrfvle_cfg.sv
module mrfvle_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mrfvle_pkg::ADDR_W-1:0] paddr,
  input  logic [mrfvle_pkg::DATA_W-1:0] pwdata,
  output logic [mrfvle_pkg::DATA_W-1:0] prdata,
  output mrfvle_pkg::gains_t           gains
);
  import mrfvle_pkg::*;

  logic wr_en;

  assign wr_en = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      gains.mean_gain      <= GAIN_W'(8388608);
      gains.neighbour_gain <= GAIN_W'(2796203);
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_MEAN_GAIN:      gains.mean_gain      <= pwdata[GAIN_W-1:0];
        REG_NEIGHBOUR_GAIN: gains.neighbour_gain <= pwdata[GAIN_W-1:0];
        default:            gains.mean_gain      <= gains.mean_gain;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_MEAN_GAIN:      prdata = DATA_W'(gains.mean_gain);
      REG_NEIGHBOUR_GAIN: prdata = DATA_W'(gains.neighbour_gain);
      default:            prdata = '0;
    endcase
  end

endmodule

>>> src/mrfvle_front.sv
module mrfvle_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  mrfvle_pkg::in_item_t in_item,
  output logic                 full,
  input  logic                 job_full,
  output logic                 job_push,
  output mrfvle_pkg::job_t     job
);
  import mrfvle_pkg::*;

  logic [CNT_W-1:0]  tri_count;
  logic [LIN_W-1:0]  lin_sum;
  logic [QUAD_W-1:0] quad_sum;

  logic [CNT_W-1:0]  tri_count_next;
  logic [LIN_W-1:0]  lin_sum_next;
  logic [QUAD_W-1:0] quad_sum_next;

  logic              accept;
  logic              add_ok;
  logic [12:0]       b13, c13, quad_inc;

  assign full   = job_full;
  assign accept = push & ~full;
  assign add_ok = in_item.has_triangle & (tri_count < TRI_LIMIT);

  // b^2 + c^2 - bc is never negative
  assign b13      = 13'(in_item.neighbour_delta_a);
  assign c13      = 13'(in_item.neighbour_delta_b);
  assign quad_inc = b13 * b13 + c13 * c13 - b13 * c13;

  always_comb begin
    tri_count_next = tri_count;
    lin_sum_next   = lin_sum;
    quad_sum_next  = quad_sum;
    if (add_ok) begin
      tri_count_next = tri_count + CNT_W'(1);
      lin_sum_next   = lin_sum + LIN_W'(b13) + LIN_W'(c13);
      quad_sum_next  = quad_sum + QUAD_W'(quad_inc);
    end
  end

  assign job_push      = accept & in_item.last_triangle;
  assign job.tri_count = tri_count_next;
  assign job.lin_sum   = lin_sum_next;
  assign job.quad_sum  = quad_sum_next;
  assign job.mean      = in_item.vertex_mean;

  always_ff @(posedge clk) begin
    if (rst) begin
      tri_count <= '0;
      lin_sum   <= '0;
      quad_sum  <= '0;
    end else if (accept) begin
      if (in_item.last_triangle) begin
        tri_count <= '0;
        lin_sum   <= '0;
        quad_sum  <= '0;
      end else begin
        tri_count <= tri_count_next;
        lin_sum   <= lin_sum_next;
        quad_sum  <= quad_sum_next;
      end
    end
  end

endmodule

>>> src/mrfvle_job_queue.sv
module mrfvle_job_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  mrfvle_pkg::job_t wr_job,
  output logic             full,
  input  logic             rd,
  output logic             empty,
  output mrfvle_pkg::job_t rd_job
);
  import mrfvle_pkg::*;

  job_t               slots [JQ_DEPTH];
  logic [JQ_AW-1:0]   wr_ptr, rd_ptr;
  logic [JQ_AW:0]     count;
  logic               do_wr, do_rd;

  assign full   = (count == (JQ_AW+1)'(JQ_DEPTH));
  assign empty  = (count == '0);
  assign do_wr  = wr & ~full;
  assign do_rd  = rd & ~empty;
  assign rd_job = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == JQ_AW'(JQ_DEPTH - 1)) ? '0 : wr_ptr + JQ_AW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == JQ_AW'(JQ_DEPTH - 1)) ? '0 : rd_ptr + JQ_AW'(1);
      end
      count <= count + (JQ_AW+1)'(do_wr) - (JQ_AW+1)'(do_rd);
    end
  end

endmodule

>>> src/mrfvle_back.sv
module mrfvle_back (
  input  logic                  clk,
  input  logic                  rst,
  input  mrfvle_pkg::gains_t    gains,
  input  logic                  job_empty,
  input  mrfvle_pkg::job_t      job_head,
  output logic                  job_pop,
  input  logic                  pop,
  output logic                  empty,
  output mrfvle_pkg::out_item_t out_item
);
  import mrfvle_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t            state, state_next;
  job_t              cur;
  logic [STEP_W-1:0] step;
  logic              issue, issue_last, space_ok;

  // stage 1
  logic              v1, last1;
  logic [STEP_W-1:0] d1;
  logic [DSQ_W-1:0]  dsq1, dm2_1;
  logic [DL_W-1:0]   dl1;
  logic [CNT_W-1:0]  t1;
  logic [QUAD_W-1:0] q1;
  logic [STEP_W-1:0] dm;
  // stage 2
  logic              v2, last2;
  logic [STEP_W-1:0] d2;
  logic [HALF_W-1:0] half2;
  logic [MT_W-1:0]   mt2;
  logic [19:0]       half_wide;
  // stage 3
  logic              v3, last3;
  logic [STEP_W-1:0] d3;
  logic [MT_W-1:0]   mt3;
  logic [NT_W-1:0]   nt3;
  logic [ENERGY_W:0] esum;

  // result queue
  out_item_t         rq [RQ_DEPTH];
  logic [RQ_AW-1:0]  rq_wr_ptr, rq_rd_ptr;
  logic [RQ_AW:0]    rq_count;
  logic [RQ_AW+1:0]  committed;
  logic              rq_rd;

  // reserve queue room for everything in flight
  assign committed = (RQ_AW+2)'(rq_count) + (RQ_AW+2)'(v1) + (RQ_AW+2)'(v2)
                     + (RQ_AW+2)'(v3);
  assign space_ok  = committed < (RQ_AW+2)'(RQ_DEPTH);

  always_comb begin
    state_next = state;
    job_pop    = 1'b0;
    issue      = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (!job_empty) begin
          job_pop    = 1'b1;
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        issue = space_ok;
        if (space_ok && step == LAST_STEP) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign issue_last = issue & (step == LAST_STEP);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      if (job_pop) begin
        step <= '0;
      end else if (issue) begin
        step <= step + STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      cur <= job_head;
    end
  end

  assign dm = (step > cur.mean) ? step - cur.mean : cur.mean - step;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= issue;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // half = T*d^2 + Q - d*L, sum of non-negative per-triangle terms
  assign half_wide = 20'(t1) * 20'(dsq1) + 20'(q1) - 20'(dl1);

  always_ff @(posedge clk) begin
    d1    <= step;
    last1 <= issue_last;
    dsq1  <= DSQ_W'(step) * DSQ_W'(step);
    dm2_1 <= DSQ_W'(dm) * DSQ_W'(dm);
    dl1   <= DL_W'(step) * DL_W'(cur.lin_sum);
    t1    <= cur.tri_count;
    q1    <= cur.quad_sum;

    d2    <= d1;
    last2 <= last1;
    half2 <= half_wide[HALF_W-1:0];
    mt2   <= MT_W'(gains.mean_gain) * MT_W'(dm2_1);

    d3    <= d2;
    last3 <= last2;
    mt3   <= mt2;
    nt3   <= NT_W'(gains.neighbour_gain) * NT_W'({half2, 1'b0});
  end

  assign esum = (ENERGY_W+1)'(mt3) + (ENERGY_W+1)'(nt3);

  always_ff @(posedge clk) begin
    if (v3) begin
      rq[rq_wr_ptr].step_index <= d3;
      rq[rq_wr_ptr].energy     <= esum[ENERGY_W] ? '1 : esum[ENERGY_W-1:0];
      rq[rq_wr_ptr].last_step  <= last3;
    end
  end

  assign empty    = (rq_count == '0);
  assign rq_rd    = pop & ~empty;
  assign out_item = rq[rq_rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      rq_wr_ptr <= '0;
      rq_rd_ptr <= '0;
      rq_count  <= '0;
    end else begin
      if (v3) begin
        rq_wr_ptr <= (rq_wr_ptr == RQ_AW'(RQ_DEPTH - 1)) ? '0 : rq_wr_ptr + RQ_AW'(1);
      end
      if (rq_rd) begin
        rq_rd_ptr <= (rq_rd_ptr == RQ_AW'(RQ_DEPTH - 1)) ? '0 : rq_rd_ptr + RQ_AW'(1);
      end
      rq_count <= rq_count + (RQ_AW+1)'(v3) - (RQ_AW+1)'(rq_rd);
    end
  end

  a_rq_bound: assert property (@(posedge clk) disable iff (rst)
    committed <= (RQ_AW+2)'(RQ_DEPTH))
    else $error("result queue over-committed");

  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    issue_last |=> state == ST_IDLE)
    else $error("run continued past last step");

  a_pop_only_idle: assert property (@(posedge clk) disable iff (rst)
    job_pop |-> state == ST_IDLE && !v1 || state == ST_IDLE)
    else $error("job taken while a run is active");

  a_last_tag: assert property (@(posedge clk) disable iff (rst)
    v3 && last3 |-> d3 == LAST_STEP)
    else $error("last flag on wrong step");

endmodule

>>> bench/mrf_vertex_label_energy_checker.sv
module mrf_vertex_label_energy_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic                          pready,
  input  logic [mrfvle_pkg::ADDR_W-1:0] paddr,
  input  logic [mrfvle_pkg::DATA_W-1:0] pwdata,
  input  logic                          push,
  input  logic                          full,
  input  mrfvle_pkg::in_item_t          in_item,
  input  logic                          pop,
  input  logic                          empty,
  input  mrfvle_pkg::out_item_t         out_item,
  output int                            mismatches,
  output int                            outstanding,
  output int                            checked
);
  timeunit 1ns;
  timeprecision 1ps;

  import mrfvle_pkg::*;

  localparam longint unsigned ENERGY_CAP = 64'hFFFF_FFFF_FFFF;

  // gains as last written over the register port
  logic [GAIN_W-1:0] mean_gain_q;
  logic [GAIN_W-1:0] nbr_gain_q;

  // per-vertex sums
  logic [CNT_W-1:0]  tri_cnt;
  logic [LIN_W-1:0]  lin_acc;
  logic [QUAD_W-1:0] quad_acc;
  logic [STEP_W-1:0] mean_q;

  out_item_t energy_q[$];
  int        n_bad;
  int        n_checked;

  function automatic logic [ENERGY_W-1:0] step_energy(input logic [STEP_W-1:0] d);
    longint unsigned dd, mm, dm, t, l, q, mg, ng, half, e;
    dd   = d;
    mm   = mean_q;
    t    = tri_cnt;
    l    = lin_acc;
    q    = quad_acc;
    mg   = mean_gain_q;
    ng   = nbr_gain_q;
    dm   = (dd > mm) ? dd - mm : mm - dd;
    // T*d^2 + Q - d*L, a sum of non-negative terms per triangle
    half = t * dd * dd + q - dd * l;
    e    = mg * dm * dm + ng * (64'd2 * half);
    return (e > ENERGY_CAP) ? ENERGY_CAP[ENERGY_W-1:0] : e[ENERGY_W-1:0];
  endfunction

  task automatic fold_item(input in_item_t it);
    int unsigned b, c;
    out_item_t   res;
    b      = it.neighbour_delta_a;
    c      = it.neighbour_delta_b;
    mean_q = it.vertex_mean;
    if (it.has_triangle && tri_cnt < TRI_LIMIT) begin
      tri_cnt  = tri_cnt + 1'b1;
      lin_acc  = LIN_W'(lin_acc + b + c);
      quad_acc = QUAD_W'(quad_acc + b * b + c * c - b * c);
    end
    if (it.last_triangle) begin
      for (int d = 0; d < STEPS; d++) begin
        res.step_index = STEP_W'(d);
        res.energy     = step_energy(STEP_W'(d));
        res.last_step  = (d == STEPS - 1);
        energy_q.insert(energy_q.size(), res);
      end
      tri_cnt  = '0;
      lin_acc  = '0;
      quad_acc = '0;
    end
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (energy_q.size() == 0) begin
      n_bad++;
      if (n_bad <= 10)
        $display("unexpected energy result: step %0d energy %0d last %0b",
                 got.step_index, got.energy, got.last_step);
    end else begin
      want = energy_q.pop_front();
      n_checked++;
      if (got.step_index !== want.step_index || got.energy !== want.energy ||
          got.last_step !== want.last_step) begin
        n_bad++;
        if (n_bad <= 10)
          $display("mismatch: want step %0d energy %0d last %0b, got %0d %0d %0b",
                   want.step_index, want.energy, want.last_step,
                   got.step_index, got.energy, got.last_step);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      mean_gain_q = GAIN_W'(8388608);
      nbr_gain_q  = GAIN_W'(2796203);
      tri_cnt     = '0;
      lin_acc     = '0;
      quad_acc    = '0;
      mean_q      = '0;
      energy_q.delete();
      n_bad       = 0;
      n_checked   = 0;
      mismatches  <= 0;
      outstanding <= 0;
      checked     <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_MEAN_GAIN)
          mean_gain_q = pwdata[GAIN_W-1:0];
        else
          nbr_gain_q = pwdata[GAIN_W-1:0];
      end
      if (pop && !empty)
        check_result(out_item);
      if (push && !full)
        fold_item(in_item);
      mismatches  <= n_bad;
      outstanding <= energy_q.size();
      checked     <= n_checked;
    end
  end

endmodule

>>> bench/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import mrfvle_pkg::*;

  // Timeout: worst case is every item closing a vertex (32 energies each)
  // with every energy waiting out a long pop stall; this is several times that
  // for the item counts used here.
  localparam int CYCLE_LIMIT = 2_000_000;
  // back end runs a load state per vertex plus a 3-stage pipe; once every
  // energy has been popped, this wait lets it go quiet
  localparam int SETTLE      = 8;
  localparam int PHASE_ITEMS = 65;

  logic              clk     = 1'b0;
  logic              rst     = 1'b1;
  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [ADDR_W-1:0] paddr   = '0;
  logic [DATA_W-1:0] pwdata  = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              push    = 1'b0;
  in_item_t          in_item = '0;
  logic              full;
  logic              empty;
  logic              pop     = 1'b0;
  out_item_t         out_item;

  int mismatches;
  int outstanding;
  int checked;

  int cycle_count  = 0;
  int items_sent   = 0;
  int vertices     = 0;
  int gain_writes  = 0;
  int pop_hold     = 0;
  bit calm         = 1'b0;  // when set, neither side idles

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  mrf_vertex_label_energy_unit uut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .push    (push),
    .in_item (in_item),
    .full    (full),
    .empty   (empty),
    .pop     (pop),
    .out_item(out_item)
  );

  mrf_vertex_label_energy_checker energy_checker (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .push       (push),
    .full       (full),
    .in_item    (in_item),
    .pop        (pop),
    .empty      (empty),
    .out_item   (out_item),
    .mismatches (mismatches),
    .outstanding(outstanding),
    .checked    (checked)
  );

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("mrf_vertex_label_energy_unit regression: fail");
      $finish;
    end
  end

  // Result side: pop mostly high, short stalls now and then, rarely a long one.
  // pop_hold counts down the cycles of a stall in progress.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (pop_hold > 0) begin
      pop      <= 1'b0;
      pop_hold <= pop_hold - 1;
    end else if (calm || $urandom_range(0, 99) < 75) begin
      pop <= 1'b1;
    end else begin
      pop      <= 1'b0;
      pop_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 24)
                                              : $urandom_range(0, 2);
    end
  end

  // Sender gap length: mostly back to back, some short, a few long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Steps mostly inside 0..STEPS-1, sometimes anywhere in the 6-bit range.
  function automatic logic [STEP_W-1:0] rand_step();
    if ($urandom_range(0, 4) == 0) return STEP_W'($urandom_range(0, 63));
    return STEP_W'($urandom_range(0, STEPS - 1));
  endfunction

  function automatic in_item_t mk(input int m, input int b, input int c,
                                  input bit has_tri, input bit last);
    in_item_t it;
    it.vertex_mean       = STEP_W'(m);
    it.neighbour_delta_a = STEP_W'(b);
    it.neighbour_delta_b = STEP_W'(c);
    it.has_triangle      = has_tri;
    it.last_triangle     = last;
    return it;
  endfunction

  // Present one item and hold it until accepted; push stays high into the
  // next item unless a gap is drawn. full is read right after the edge, so it
  // is the value that decided acceptance at that edge.
  task automatic put_item(input in_item_t it);
    int g;
    push    <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (full) @(posedge clk);
    items_sent++;
    if (it.last_triangle) vertices++;
    g = pick_gap();
    if (g > 0) begin
      push <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // Stop sending and wait until every expected energy has been popped.
  // One edge first so the checker's count reflects the final item.
  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Setup cycle, then access cycle; the write lands on the edge with pready.
  task automatic reg_write(input logic reg_sel, input logic [GAIN_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_gains(input logic [GAIN_W-1:0] mg, input logic [GAIN_W-1:0] ng);
    drain();
    reg_write(REG_MEAN_GAIN, mg);
    reg_write(REG_NEIGHBOUR_GAIN, ng);
    gain_writes++;
  endtask

  // One vertex: a run of items, the final one flagged last. Around one item
  // in ten is empty; occasionally the run exceeds the triangle cap.
  task automatic send_vertex();
    int       k, r;
    in_item_t it;
    r = $urandom_range(0, 99);
    if (r < 5)       k = 1;
    else if (r < 85) k = $urandom_range(2, 8);
    else if (r < 95) k = $urandom_range(9, 16);
    else             k = $urandom_range(17, 20);
    for (int i = 0; i < k; i++) begin
      it.vertex_mean       = rand_step();
      it.neighbour_delta_a = rand_step();
      it.neighbour_delta_b = rand_step();
      it.has_triangle      = ($urandom_range(0, 9) != 0);
      it.last_triangle     = (i == k - 1);
      put_item(it);
    end
  endtask

  task automatic random_phase();
    int start;
    start = items_sent;
    while (items_sent - start < PHASE_ITEMS) send_vertex();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, reset gains.
    // empty last item with no sums: mean term alone
    put_item(mk(0, 0, 0, 1'b0, 1'b1));
    // mean at the top of the 6-bit range, past STEPS
    put_item(mk(63, 0, 0, 1'b0, 1'b1));
    // corner extremes; the mean used is the one on the last item
    put_item(mk(5, 63, 63, 1'b1, 1'b0));
    put_item(mk(17, 0, 0, 1'b1, 1'b0));
    put_item(mk(40, 0, 63, 1'b1, 1'b1));
    // sixteen triangles fill the cap, an empty item in between, and the
    // seventeenth triangle on the last item must be dropped
    for (int i = 0; i < 16; i++)
      put_item(mk(rand_step(), i * 4 + 3, 63 - i * 4, 1'b1, 1'b0));
    put_item(mk(9, 45, 12, 1'b0, 1'b0));
    put_item(mk(31, 63, 0, 1'b1, 1'b1));

    // Random part over several gain settings, extremes included.
    // Each set_gains also makes the sender wait for every result to come.
    set_gains(24'hFFFFFF, 24'hFFFFFF);
    random_phase();
    set_gains(24'h000000, 24'h000000);
    random_phase();
    calm = 1'b1;  // one phase with no idling on either side
    set_gains(24'hFFFFFF, 24'h000000);
    random_phase();
    calm = 1'b0;
    set_gains(24'h000000, 24'hFFFFFF);
    random_phase();
    set_gains(24'h000001, 24'h000001);
    random_phase();
    set_gains(GAIN_W'($urandom_range(0, 24'hFFFFFF)), GAIN_W'($urandom_range(0, 24'hFFFFFF)));
    random_phase();
    set_gains(GAIN_W'(8388608), GAIN_W'(2796203));
    random_phase();

    drain();

    $display("covered %0d items in %0d vertices under %0d gain settings",
             items_sent, vertices, gain_writes + 1);
    $display("%0d step energies compared, %0d mismatches", checked, mismatches);
    if (mismatches == 0 && outstanding == 0)
      $display("mrf_vertex_label_energy_unit regression: pass");
    else
      $display("mrf_vertex_label_energy_unit regression: fail");
    $finish;
  end

endmodule
